FILE: hw/rtl/fhpu_pkg.sv
package fhpu_pkg;

  // Entry kinds
  localparam logic [3:0] KIND_DIR     = 4'd2;
  localparam logic [3:0] KIND_REGULAR = 4'd5;
  localparam logic [3:0] KIND_UNKNOWN = 4'd7;
  localparam logic [3:0] KIND_LAST    = 4'd8;
  localparam logic [3:0] ZERO_SLOT    = 4'd9;
  localparam int KIND_SLOTS = 10;
  localparam int TABLE_LEN  = 32;

  // Request types
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Read address map
  localparam logic [6:0] ADDR_SUM_BASE  = 7'd64;
  localparam logic [6:0] ADDR_KIND_BASE = 7'd112;
  localparam logic [6:0] ADDR_TOTAL     = 7'd122;
  localparam logic [6:0] ADDR_LFILE     = 7'd123;
  localparam logic [6:0] ADDR_LDIR      = 7'd124;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  entry_kind;
    logic [62:0] entry_size;
    logic [31:0] dir_entries;
    logic [6:0]  read_addr;
  } in_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        addr_error;
  } out_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic        is_read;
    logic [3:0]  kind;
    logic [62:0] size;
    logic [31:0] dents;
    logic [6:0]  addr;
  } cmd_t;

  // Fixed bin upper bounds; anything past the table is all ones
  function automatic logic [63:0] bound_of(input int unsigned idx);
    logic [63:0] b;
    case (idx)
      0:       b = 64'd0;
      1:       b = 64'd4 << 10;
      2:       b = 64'd8 << 10;
      3:       b = 64'd16 << 10;
      4:       b = 64'd32 << 10;
      5:       b = 64'd64 << 10;
      6:       b = 64'd512 << 10;
      7:       b = 64'd1 << 20;
      8:       b = 64'd4 << 20;
      9:       b = 64'd8 << 20;
      10:      b = 64'd16 << 20;
      11:      b = 64'd32 << 20;
      12:      b = 64'd64 << 20;
      13:      b = 64'd128 << 20;
      14:      b = 64'd256 << 20;
      15:      b = 64'd512 << 20;
      16:      b = 64'd1 << 30;
      17:      b = 64'd4 << 30;
      18:      b = 64'd8 << 30;
      19:      b = 64'd16 << 30;
      20:      b = 64'd32 << 30;
      21:      b = 64'd64 << 30;
      22:      b = 64'd128 << 30;
      23:      b = 64'd256 << 30;
      24:      b = 64'd512 << 30;
      25:      b = 64'd1 << 40;
      26:      b = 64'd2 << 40;
      27:      b = 64'd4 << 40;
      28:      b = 64'd8 << 40;
      29:      b = 64'd16 << 40;
      30:      b = 64'd32 << 40;
      31:      b = 64'd64 << 40;
      default: b = '1;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/fhpu_ram.sv
module fhpu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a same-edge write is not seen by the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fhpu_fifo.sv
module fhpu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push_ok) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop_ok) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/fhpu_front.sv
module fhpu_front #(
  parameter int NUM_BINS = 33
) (
  input  fhpu_pkg::in_t                 in_item,
  output fhpu_pkg::cmd_t                cmd,
  output logic [$clog2(NUM_BINS)-1:0]   idx
);

  import fhpu_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);

  logic [NUM_BINS-2:0] ge;
  logic [BIN_W-1:0]    bin;

  // bounds are nondecreasing, so the first hit is the bin
  always_comb begin
    for (int i = 0; i < NUM_BINS - 1; i++) begin
      ge[i] = (bound_of(i) >= {1'b0, in_item.entry_size});
    end
    bin = BIN_W'(NUM_BINS - 1);
    for (int i = NUM_BINS - 2; i >= 0; i--) begin
      if (ge[i]) begin
        bin = BIN_W'(i);
      end
    end
  end

  always_comb begin
    cmd.is_read = (in_item.req_type == REQ_READ);
    cmd.kind    = (in_item.entry_kind > KIND_LAST) ? KIND_UNKNOWN : in_item.entry_kind;
    cmd.size    = in_item.entry_size;
    cmd.dents   = in_item.dir_entries;
    cmd.addr    = in_item.read_addr;
    // reads use the same RAM index: bin count a and byte sum 64+a share low bits
    idx = cmd.is_read ? in_item.read_addr[BIN_W-1:0] : bin;
  end

endmodule

FILE: hw/rtl/fhpu_back.sv
module fhpu_back #(
  parameter int NUM_BINS = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  fhpu_pkg::cmd_t                cmd,
  input  logic [$clog2(NUM_BINS)-1:0]   cmd_idx,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output fhpu_pkg::out_t                res
);

  import fhpu_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int VLD_N = 1 << BIN_W;

  // execute stage
  logic             b_vld_r;
  cmd_t             b_cmd_r;
  logic [BIN_W-1:0] b_idx_r;
  logic             b_adv, b_take;

  // last bin write, for forwarding past the read-first RAM
  logic             wr_vld_r;
  logic [BIN_W-1:0] wr_addr_r;
  logic [63:0]      cnt_wd_r, sum_wd_r;
  logic [VLD_N-1:0] bin_vld_r;

  logic [63:0] kind_cnt_r [KIND_SLOTS];
  logic [63:0] total_r;
  logic [62:0] lfile_r;
  logic [31:0] ldir_r;

  logic [63:0] cnt_rdata, sum_rdata, cnt_old, sum_old, cnt_new, sum_new;
  logic        fwd_hit, rec, reg_wr;

  assign b_adv   = b_vld_r && (!b_cmd_r.is_read || !res_full);
  assign b_take  = !b_vld_r || b_adv;
  assign cmd_pop = cmd_valid && b_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_take) begin
      b_vld_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      b_cmd_r <= cmd;
      b_idx_r <= cmd_idx;
    end
  end

  fhpu_ram #(.WIDTH(64), .DEPTH(NUM_BINS)) u_cnt_ram (
    .clk   (clk),
    .we    (reg_wr),
    .waddr (b_idx_r),
    .wdata (cnt_new),
    .re    (cmd_pop),
    .raddr (cmd_idx),
    .rdata (cnt_rdata)
  );

  fhpu_ram #(.WIDTH(64), .DEPTH(NUM_BINS)) u_sum_ram (
    .clk   (clk),
    .we    (reg_wr),
    .waddr (b_idx_r),
    .wdata (sum_new),
    .re    (cmd_pop),
    .raddr (cmd_idx),
    .rdata (sum_rdata)
  );

  assign fwd_hit = wr_vld_r && (wr_addr_r == b_idx_r);
  assign cnt_old = fwd_hit ? cnt_wd_r : (bin_vld_r[b_idx_r] ? cnt_rdata : '0);
  assign sum_old = fwd_hit ? sum_wd_r : (bin_vld_r[b_idx_r] ? sum_rdata : '0);
  assign cnt_new = cnt_old + 64'd1;
  assign sum_new = sum_old + {1'b0, b_cmd_r.size};

  assign rec    = b_adv && !b_cmd_r.is_read;
  assign reg_wr = rec && (b_cmd_r.kind == KIND_REGULAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r  <= 1'b0;
      bin_vld_r <= '0;
    end else if (reg_wr) begin
      wr_vld_r           <= 1'b1;
      bin_vld_r[b_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (reg_wr) begin
      wr_addr_r <= b_idx_r;
      cnt_wd_r  <= cnt_new;
      sum_wd_r  <= sum_new;
    end
  end

  // scalar counters, one incrementer per slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KIND_SLOTS; k++) begin
        kind_cnt_r[k] <= '0;
      end
      total_r <= '0;
      lfile_r <= '0;
      ldir_r  <= '0;
    end else if (rec) begin
      for (int k = 0; k < KIND_SLOTS - 1; k++) begin
        if (b_cmd_r.kind == 4'(k)) begin
          kind_cnt_r[k] <= kind_cnt_r[k] + 64'd1;
        end
      end
      if (reg_wr) begin
        total_r <= total_r + {1'b0, b_cmd_r.size};
        if (b_cmd_r.size == '0) begin
          kind_cnt_r[ZERO_SLOT] <= kind_cnt_r[ZERO_SLOT] + 64'd1;
        end
        if (b_cmd_r.size > lfile_r) begin
          lfile_r <= b_cmd_r.size;
        end
      end
      if (b_cmd_r.kind == KIND_DIR && b_cmd_r.dents > ldir_r) begin
        ldir_r <= b_cmd_r.dents;
      end
    end
  end

  // read decode
  always_comb begin
    res.read_data  = '0;
    res.addr_error = 1'b0;
    if (b_cmd_r.addr < ADDR_SUM_BASE) begin
      if ({1'b0, b_cmd_r.addr} < 8'(NUM_BINS)) begin
        res.read_data = cnt_old;
      end else begin
        res.addr_error = 1'b1;
      end
    end else if (b_cmd_r.addr < ADDR_KIND_BASE) begin
      if ({2'b00, b_cmd_r.addr[5:0]} < 8'(NUM_BINS)) begin
        res.read_data = sum_old;
      end else begin
        res.addr_error = 1'b1;
      end
    end else if (b_cmd_r.addr < ADDR_TOTAL) begin
      res.read_data = kind_cnt_r[b_cmd_r.addr[3:0]];
    end else if (b_cmd_r.addr == ADDR_TOTAL) begin
      res.read_data = total_r;
    end else if (b_cmd_r.addr == ADDR_LFILE) begin
      res.read_data = {1'b0, lfile_r};
    end else if (b_cmd_r.addr == ADDR_LDIR) begin
      res.read_data = {32'd0, ldir_r};
    end else begin
      res.addr_error = 1'b1;
    end
  end

  assign res_push = b_adv && b_cmd_r.is_read;

endmodule

FILE: hw/rtl/file_size_histogram_profiler_unit.sv
// Channel  | Handshake          | Payload            | Transaction
// ---------+--------------------+--------------------+----------------------------------
// in_      | in_push / in_full  | in_data  (in_t)    | one entry record or read request
// out_     | out_pop / out_empty| out_data (out_t)   | one counter value per read request
//
// Sustains one input transaction per cycle unless a read is stalled on a full result
// queue; the bin RMW is a two-stage read/write on the count and sum RAMs with forwarding
// of the last write, so back-to-back hits on the same bin do not stall.
// A read request passes the command queue and the back end's execute stage, then lands
// in the result queue; out_empty then falls and the result can be popped.
// Reset (rst_n low, synchronous) clears queues, counters and per-bin valid bits;
// no clearing pass over the bin RAMs is needed.
// A full result queue stalls the back end only while it holds a read request; records
// retire regardless, but everything queued behind a stalled read waits. The command
// queue absorbs short stalls before in_full rises.
module file_size_histogram_profiler_unit #(
  parameter int NUM_BINS = 33
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  fhpu_pkg::in_t   in_data,
  input  logic            out_pop,
  output logic            out_empty,
  output fhpu_pkg::out_t  out_data
);

  import fhpu_pkg::*;

  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int CMD_W   = $bits(cmd_t) + BIN_W;
  localparam int Q_DEPTH = 4;
  localparam int R_DEPTH = 2;

  // front: classify (kind cleanup, bin search)
  cmd_t             f_cmd;
  logic [BIN_W-1:0] f_idx;

  // command queue between front and back
  logic [CMD_W-1:0] q_rdata;
  logic             mid_empty, cmd_pop;
  cmd_t             q_cmd;
  logic [BIN_W-1:0] q_idx;

  // result queue
  logic             res_push, res_full;
  out_t             res;
  logic [$bits(out_t)-1:0] r_rdata;

  fhpu_front #(.NUM_BINS(NUM_BINS)) u_front (
    .in_item (in_data),
    .cmd     (f_cmd),
    .idx     (f_idx)
  );

  fhpu_fifo #(.WIDTH(CMD_W), .DEPTH(Q_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata ({f_idx, f_cmd}),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (mid_empty)
  );

  assign q_cmd = q_rdata[$bits(cmd_t)-1:0];
  assign q_idx = q_rdata[CMD_W-1:$bits(cmd_t)];

  // back: bin RMW, scalar counters, read mux
  fhpu_back #(.NUM_BINS(NUM_BINS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!mid_empty),
    .cmd       (q_cmd),
    .cmd_idx   (q_idx),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  fhpu_fifo #(.WIDTH($bits(out_t)), .DEPTH(R_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (r_rdata),
    .empty (out_empty)
  );

  assign out_data = r_rdata;

`ifndef SYNTH
  // back end never pushes a result into a full queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");

  // back end only takes commands that exist
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !mid_empty) else $error("command popped from empty queue");

  // an accepted transaction is visible in the command queue next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !mid_empty) else $error("accepted transaction lost");
`endif

endmodule

FILE: test/file_size_histogram_profiler_unit_test.sv
`timescale 1ns / 100ps

// Streams entry records and counter reads into the profiler, keeps a shadow
// copy of every counter, and checks each read transaction against it.
module file_size_histogram_profiler_unit_test;
  import fhpu_pkg::*;

  localparam int N_BINS = 33;
  localparam int RANDOM_ITEMS = 1825;
  localparam int SQUEEZE_ITEMS = 300;   // read-heavy burst while the reader holds off
  localparam int SQUEEZE_CYCLES = 400;  // length of the long reader hold-off
  localparam int SETTLE_CYCLES = 20;    // idle time after the last owed read is checked

  // Bin bounds as multiplier << unit shift (KiB, MiB, GiB, TiB groups)
  localparam int unsigned STEP_MULT [32] = '{
    0, 4, 8, 16, 32, 64, 512,
    1, 4, 8, 16, 32, 64, 128, 256, 512,
    1, 4, 8, 16, 32, 64, 128, 256, 512,
    1, 2, 4, 8, 16, 32, 64
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_t  in_data = '0;
  logic out_pop = 1'b0;
  logic out_empty;
  out_t out_data;

  always #4 clk = ~clk;

  file_size_histogram_profiler_unit #(
    .NUM_BINS(N_BINS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------
  // Shadow profile: the counters the block should hold
  // ---------------------------------------------------------------------
  logic [63:0] bin_limit [N_BINS];
  logic [63:0] bin_hits [N_BINS];
  logic [63:0] bin_bytes [N_BINS];
  logic [63:0] kind_tally [KIND_SLOTS];
  logic [63:0] bytes_total;
  logic [62:0] biggest_file;
  logic [31:0] biggest_dir;

  out_t pending_reads [$];  // read results still owed by the block

  int mismatches = 0;
  int records_sent = 0;
  int reads_sent = 0;
  int reads_checked = 0;
  int full_cycles = 0;
  int long_holds = 0;
  bit squeeze_req = 1'b0;

  function automatic void clear_profile();
    int shift;
    for (int i = 0; i < N_BINS; i++) begin
      if (i < 7) shift = 10;
      else if (i < 16) shift = 20;
      else if (i < 25) shift = 30;
      else shift = 40;
      bin_limit[i] = (i < TABLE_LEN) ? (64'(STEP_MULT[i]) << shift) : '1;
      bin_hits[i] = '0;
      bin_bytes[i] = '0;
    end
    // top bin catches everything
    bin_limit[N_BINS-1] = '1;
    foreach (kind_tally[k]) kind_tally[k] = '0;
    bytes_total = '0;
    biggest_file = '0;
    biggest_dir = '0;
  endfunction

  function automatic int size_bin(input logic [62:0] sz);
    for (int i = 0; i < N_BINS - 1; i++)
      if (bin_limit[i] >= {1'b0, sz}) return i;
    return N_BINS - 1;
  endfunction

  // Applies one transaction to the shadow profile; returns 1 when it owes a read result.
  function automatic bit profile_step(input in_t item, output out_t res);
    int unsigned a;
    logic [3:0] kind;
    int b;
    res = '0;
    if (item.req_type == REQ_READ) begin
      a = item.read_addr;
      res.addr_error = 1'b0;
      if (a < ADDR_SUM_BASE) begin
        if (a < N_BINS) res.read_data = bin_hits[a];
        else res.addr_error = 1'b1;
      end else if (a < ADDR_KIND_BASE) begin
        if (a - ADDR_SUM_BASE < N_BINS) res.read_data = bin_bytes[a - ADDR_SUM_BASE];
        else res.addr_error = 1'b1;
      end else if (a < ADDR_KIND_BASE + KIND_SLOTS) begin
        res.read_data = kind_tally[a - ADDR_KIND_BASE];
      end else if (a == ADDR_TOTAL) begin
        res.read_data = bytes_total;
      end else if (a == ADDR_LFILE) begin
        res.read_data = {1'b0, biggest_file};
      end else if (a == ADDR_LDIR) begin
        res.read_data = {32'd0, biggest_dir};
      end else begin
        res.addr_error = 1'b1;
      end
      return 1'b1;
    end
    kind = (item.entry_kind > KIND_LAST) ? KIND_UNKNOWN : item.entry_kind;
    if (kind == KIND_REGULAR) begin
      kind_tally[KIND_REGULAR]++;
      bytes_total += {1'b0, item.entry_size};
      if (item.entry_size == '0) kind_tally[ZERO_SLOT]++;
      else if (item.entry_size > biggest_file) biggest_file = item.entry_size;
      b = size_bin(item.entry_size);
      bin_hits[b]++;
      bin_bytes[b] += {1'b0, item.entry_size};
    end else begin
      kind_tally[kind]++;
      if (kind == KIND_DIR && item.dir_entries > biggest_dir) biggest_dir = item.dir_entries;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic in_t read_req(input int unsigned addr);
    in_t it;
    it = '0;
    it.req_type = REQ_READ;
    it.read_addr = addr[6:0];
    return it;
  endfunction

  function automatic in_t record_req(input logic [3:0] kind, input logic [62:0] size,
                                     input logic [31:0] dents);
    in_t it;
    it = '0;
    it.req_type = REQ_RECORD;
    it.entry_kind = kind;
    it.entry_size = size;
    it.dir_entries = dents;
    return it;
  endfunction

  // Sizes cluster on bin edges (edge-1, edge, edge+1), with zeros, small and full-width values.
  function automatic logic [62:0] random_size();
    int r;
    logic [63:0] edge_val;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 55) begin
      edge_val = bin_limit[$urandom_range(0, N_BINS - 1)];
      edge_val = edge_val + 64'($urandom_range(0, 2)) - 64'd1;
      return edge_val[62:0];
    end
    if (r < 80) return 63'($urandom_range(0, 1 << 20));
    return 63'({$urandom, $urandom});
  endfunction

  function automatic in_t random_item(input int read_pct);
    in_t it;
    int r;
    // unused fields stay random: the block must ignore them
    it.req_type = ($urandom_range(0, 99) < read_pct) ? REQ_READ : REQ_RECORD;
    r = $urandom_range(0, 99);
    if (r < 50) it.entry_kind = KIND_REGULAR;
    else if (r < 65) it.entry_kind = KIND_DIR;
    else it.entry_kind = 4'($urandom_range(0, 15));
    it.entry_size = random_size();
    r = $urandom_range(0, 99);
    if (r < 50) it.dir_entries = $urandom;
    else if (r < 80) it.dir_entries = $urandom_range(0, 1000);
    else it.dir_entries = 32'hFFFF_FFFF - $urandom_range(0, 3);
    r = $urandom_range(0, 99);
    if (r < 30) it.read_addr = 7'($urandom_range(0, N_BINS - 1));
    else if (r < 50) it.read_addr = ADDR_SUM_BASE + 7'($urandom_range(0, N_BINS - 1));
    else if (r < 70) it.read_addr = ADDR_KIND_BASE + 7'($urandom_range(0, 12));
    else it.read_addr = 7'($urandom_range(0, 127));
    return it;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one transaction per call, push held high across back-to-back items
  // ---------------------------------------------------------------------
  task automatic offer(input in_t item, input int gap, input bit fixed, input out_t want);
    out_t res;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full);
    // accepted at this edge
    if (profile_step(item, res))
      pending_reads.insert(pending_reads.size(), fixed ? want : res);
    if (item.req_type == REQ_READ) reads_sent++;
    else records_sent++;
  endtask

  // Directed table: typed expectations only where the answer is obvious.
  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } row_t;

  row_t directed_rows [$];

  function automatic void add_row(input in_t item, input bit fixed = 1'b0,
                                  input logic [63:0] data = '0, input logic err = 1'b0);
    row_t r;
    r.item = item;
    r.fixed = fixed;
    r.want.read_data = data;
    r.want.addr_error = err;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  initial begin
    logic [3:0] plain_kinds [6];
    bit no_gaps;
    int gap;
    plain_kinds = '{4'd0, 4'd1, 4'd3, 4'd4, 4'd6, KIND_LAST};
    clear_profile();

    // fresh counters and unmapped reads
    add_row(read_req(ADDR_TOTAL), 1'b1, 64'd0, 1'b0);
    add_row(read_req(127), 1'b1, 64'd0, 1'b1);
    add_row(read_req(N_BINS), 1'b1, 64'd0, 1'b1);              // count past last bin
    add_row(read_req(ADDR_SUM_BASE + 47), 1'b1, 64'd0, 1'b1);  // sum beyond the map
    add_row(read_req(ADDR_KIND_BASE + ZERO_SLOT), 1'b1, 64'd0, 1'b0);
    // regular files: zero size, largest size, exact bin edge and one above
    add_row(record_req(KIND_REGULAR, '0, '0));
    add_row(record_req(KIND_REGULAR, '1, '0));
    add_row(record_req(KIND_REGULAR, 63'd4096, '0));
    add_row(record_req(KIND_REGULAR, 63'd4097, '0));
    add_row(record_req(KIND_REGULAR, (63'd64 << 40) + 63'd1, '0));
    // directories, widest and narrow
    add_row(record_req(KIND_DIR, '0, 32'hFFFF_FFFF));
    add_row(record_req(KIND_DIR, '0, 32'd3));
    foreach (plain_kinds[k]) add_row(record_req(plain_kinds[k], '0, '0));
    // kind codes past the list fall into unknown
    add_row(record_req(4'hF, '1, '1));
    add_row(record_req(ZERO_SLOT, '0, '0));
    add_row(read_req(ADDR_LFILE), 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    add_row(read_req(ADDR_LDIR), 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0);
    add_row(read_req(ADDR_KIND_BASE + ZERO_SLOT));
    add_row(read_req(ADDR_KIND_BASE + KIND_UNKNOWN));
    add_row(read_req(ADDR_SUM_BASE + N_BINS - 1));
    add_row(read_req(1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer(directed_rows[i].item, idle_gap(), directed_rows[i].fixed, directed_rows[i].want);

    // Random part. Opens with a read-heavy flood while the reader is held off,
    // so the result queue and then the input fill up.
    squeeze_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_gaps = (n < SQUEEZE_ITEMS) || ((n / 150) % 3 == 0);
      gap = no_gaps ? 0 : idle_gap();
      offer(random_item(n < SQUEEZE_ITEMS ? 60 : 35), gap, 1'b0, '0);
    end
    in_push <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d entry records and %0d counter reads; %0d read results checked.",
             records_sent, reads_sent, reads_checked);
    $display("Input was held off by a full block for %0d cycles; %0d long reader hold-offs.",
             full_cycles, long_holds);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Reader: random pop gaps and bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_pop <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        long_holds++;
      end
      gap = idle_gap();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      // occasional long run of pops with no idling
      repeat (($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Result check: each popped transaction against the oldest owed read
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_push && in_full) full_cycles++;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: result with none owed: read_data %h addr_error %b",
                 $time, out_data.read_data, out_data.addr_error);
        mismatches++;
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (out_data.read_data !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h",
                   $time, want.read_data, out_data.read_data);
          mismatches++;
        end
        if (out_data.addr_error !== want.addr_error) begin
          $display("%0t: addr_error expected %b actual %b",
                   $time, want.addr_error, out_data.addr_error);
          mismatches++;
        end
      end
    end
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("%0t: timed out with %0d read results still owed", $time, pending_reads.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
